// File: rtl/waypoint_agent_step_defines.svh
// Assertion macros shared by the waypoint agent RTL.
`ifndef WAYPOINT_AGENT_STEP_DEFINES_SVH
`define WAYPOINT_AGENT_STEP_DEFINES_SVH

// Checked at every clock edge outside reset.
`define WAS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked at every clock edge, reset included.
`define WAS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/was_pkg.sv
package was_pkg;

   localparam int WAYPOINT_SLOTS = 16;
   localparam int COORD_BITS     = 16;

   localparam int IDX_W   = (WAYPOINT_SLOTS > 1) ? $clog2(WAYPOINT_SLOTS) : 1;
   localparam int COUNT_W = $clog2(WAYPOINT_SLOTS + 1);
   localparam int DIFF_W  = COORD_BITS + 1;
   localparam int SQ_W    = 2 * DIFF_W;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [COORD_BITS-1:0]        radius_type;
   typedef logic signed [DIFF_W-1:0]     diff_type;
   typedef logic [SQ_W-1:0]              square_type;

   typedef enum logic {
      FUNC_ADD  = 1'b0,
      FUNC_STEP = 1'b1
   } func_type;

   typedef enum logic {
      STATUS_OK   = 1'b0,
      STATUS_FULL = 1'b1
   } status_type;

   typedef struct packed {
      logic neg;
      logic move;
   } move_type;

   // One axis of a rounded unit step: move by the sign of d when 3*d^2 >= o^2.
   function automatic move_type step_move(input diff_type d, input square_type d_sq,
                                          input square_type o_sq);
      logic [SQ_W+1:0] d_sq3;
      move_type        mv;
      d_sq3   = {2'b00, d_sq} + {1'b0, d_sq, 1'b0};
      mv.move = (d != '0) && (d_sq3 >= {2'b00, o_sq});
      mv.neg  = d[DIFF_W-1];
      return mv;
   endfunction

   function automatic coord_type apply_move(input coord_type c, input move_type mv);
      coord_type res;
      res = c;
      if (mv.move) begin
         if (mv.neg) begin
            res = c - coord_type'(1);
         end else begin
            res = c + coord_type'(1);
         end
      end
      return res;
   endfunction

endpackage

// File: rtl/waypoint_agent_step.sv
// Waypoint agent, one step per word.
//
// Input channel (req_*): req_func selects the operation. An add word appends
// waypoint (req_wp_x, req_wp_y, req_wp_r) to a circular queue; a step word
// gives the agent position (req_cur_x, req_cur_y) and may pull the next
// waypoint in as destination, then moves one unit step toward it.
// Result channel (rsp_*): exactly one result word per input word, in order,
// with the desired position, has_destination and status (queue full on add).
// A word is accepted on a rising edge with valid high and stall low.
//
// A word passes through one input register, then the queue access, squares
// and compares into the result register. Throughput is one word per cycle
// while the result channel is not stalled; the queue and destination
// registers are updated in the same cycle as the result register, so the
// next word sees them at once. The result register lets a new word enter
// while a finished result waits for the receiver.
// While rsp_stall is high the result holds, the input register fills and
// then req_stall rises; nothing is lost. Synchronous reset empties the queue,
// clears the destination and drops any word in flight.
`include "waypoint_agent_step_defines.svh"

module waypoint_agent_step (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic signed [was_pkg::COORD_BITS-1:0] req_cur_x,
   input  logic signed [was_pkg::COORD_BITS-1:0] req_cur_y,
   input  logic signed [was_pkg::COORD_BITS-1:0] req_wp_x,
   input  logic signed [was_pkg::COORD_BITS-1:0] req_wp_y,
   input  logic        [was_pkg::COORD_BITS-1:0] req_wp_r,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [was_pkg::COORD_BITS-1:0] rsp_desired_x,
   output logic signed [was_pkg::COORD_BITS-1:0] rsp_desired_y,
   output logic                                rsp_has_destination,
   output logic                                rsp_status
);

   // Input register
   logic                 in_valid_ff;
   logic                 in_valid_in;
   was_pkg::func_type    in_func_ff;
   was_pkg::coord_type   in_cur_x_ff;
   was_pkg::coord_type   in_cur_y_ff;
   was_pkg::coord_type   in_wp_x_ff;
   was_pkg::coord_type   in_wp_y_ff;
   was_pkg::radius_type  in_wp_r_ff;

   // Queue and destination state
   was_pkg::coord_type   ring_x_ff [was_pkg::WAYPOINT_SLOTS];
   was_pkg::coord_type   ring_y_ff [was_pkg::WAYPOINT_SLOTS];
   was_pkg::radius_type  ring_r_ff [was_pkg::WAYPOINT_SLOTS];
   logic [was_pkg::IDX_W-1:0]   head_ff;
   logic [was_pkg::IDX_W-1:0]   head_in;
   logic [was_pkg::COUNT_W-1:0] count_ff;
   logic [was_pkg::COUNT_W-1:0] count_in;
   was_pkg::coord_type   target_x_ff;
   was_pkg::coord_type   target_y_ff;
   was_pkg::radius_type  target_r_ff;
   was_pkg::coord_type   target_x_in;
   was_pkg::coord_type   target_y_in;
   was_pkg::radius_type  target_r_in;
   logic                 target_valid_ff;
   logic                 target_valid_in;

   // Ring write port
   logic                 ring_we;
   was_pkg::coord_type   ring_x_in;
   was_pkg::coord_type   ring_y_in;
   was_pkg::radius_type  ring_r_in;

   // Result register
   logic                 rsp_valid_ff;
   was_pkg::coord_type   rsp_x_ff;
   was_pkg::coord_type   rsp_y_ff;
   logic                 rsp_dest_ff;
   was_pkg::status_type  rsp_status_ff;
   was_pkg::coord_type   rsp_x_in;
   was_pkg::coord_type   rsp_y_in;
   was_pkg::status_type  rsp_status_in;

   // Datapath
   logic                 advance;
   logic                 req_accept;
   logic                 is_add;
   logic                 queue_full;
   logic                 queue_empty;
   logic [was_pkg::COUNT_W:0]   tail_sum;
   logic [was_pkg::IDX_W-1:0]   tail_idx;
   logic [was_pkg::IDX_W-1:0]   head_next;
   was_pkg::coord_type   front_x;
   was_pkg::coord_type   front_y;
   was_pkg::radius_type  front_r;
   was_pkg::diff_type    dx;
   was_pkg::diff_type    dy;
   was_pkg::diff_type    fdx;
   was_pkg::diff_type    fdy;
   logic signed [was_pkg::SQ_W-1:0] dx_sq_s;
   logic signed [was_pkg::SQ_W-1:0] dy_sq_s;
   logic signed [was_pkg::SQ_W-1:0] fdx_sq_s;
   logic signed [was_pkg::SQ_W-1:0] fdy_sq_s;
   was_pkg::square_type  dx_sq;
   was_pkg::square_type  dy_sq;
   was_pkg::square_type  fdx_sq;
   was_pkg::square_type  fdy_sq;
   logic [2*was_pkg::COORD_BITS-1:0] r_sq;
   logic [was_pkg::SQ_W:0]           dist_sq;
   logic                 arrived;
   logic                 take_front;
   was_pkg::move_type    mv_x_cur;
   was_pkg::move_type    mv_y_cur;
   was_pkg::move_type    mv_x_front;
   was_pkg::move_type    mv_y_front;
   was_pkg::move_type    mv_x;
   was_pkg::move_type    mv_y;

   // Handshake
   assign advance     = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign req_accept  = req_valid && !req_stall;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);

   // Queue pointers
   assign is_add      = (in_func_ff == was_pkg::FUNC_ADD);
   assign queue_full  = (count_ff == was_pkg::COUNT_W'(was_pkg::WAYPOINT_SLOTS));
   assign queue_empty = (count_ff == '0);
   assign tail_sum    = (was_pkg::COUNT_W+1)'(head_ff) + (was_pkg::COUNT_W+1)'(count_ff);
   assign tail_idx    = (tail_sum >= (was_pkg::COUNT_W+1)'(was_pkg::WAYPOINT_SLOTS))
                      ? was_pkg::IDX_W'(tail_sum - (was_pkg::COUNT_W+1)'(was_pkg::WAYPOINT_SLOTS))
                      : was_pkg::IDX_W'(tail_sum);
   assign head_next   = (head_ff == was_pkg::IDX_W'(was_pkg::WAYPOINT_SLOTS - 1))
                      ? '0 : head_ff + 1'b1;

   assign front_x = ring_x_ff[head_ff];
   assign front_y = ring_y_ff[head_ff];
   assign front_r = ring_r_ff[head_ff];

   // Distances to the held destination and to the queue front, side by side
   assign dx  = was_pkg::DIFF_W'(target_x_ff) - was_pkg::DIFF_W'(in_cur_x_ff);
   assign dy  = was_pkg::DIFF_W'(target_y_ff) - was_pkg::DIFF_W'(in_cur_y_ff);
   assign fdx = was_pkg::DIFF_W'(front_x) - was_pkg::DIFF_W'(in_cur_x_ff);
   assign fdy = was_pkg::DIFF_W'(front_y) - was_pkg::DIFF_W'(in_cur_y_ff);

   assign dx_sq_s  = dx * dx;
   assign dy_sq_s  = dy * dy;
   assign fdx_sq_s = fdx * fdx;
   assign fdy_sq_s = fdy * fdy;
   assign dx_sq    = dx_sq_s;
   assign dy_sq    = dy_sq_s;
   assign fdx_sq   = fdx_sq_s;
   assign fdy_sq   = fdy_sq_s;
   assign r_sq     = target_r_ff * target_r_ff;

   assign dist_sq    = {1'b0, dx_sq} + {1'b0, dy_sq};
   assign arrived    = target_valid_ff && (dist_sq < (was_pkg::SQ_W+1)'(r_sq));
   assign take_front = !is_add && (arrived || !target_valid_ff) && !queue_empty;

   assign mv_x_cur   = was_pkg::step_move(dx, dx_sq, dy_sq);
   assign mv_y_cur   = was_pkg::step_move(dy, dy_sq, dx_sq);
   assign mv_x_front = was_pkg::step_move(fdx, fdx_sq, fdy_sq);
   assign mv_y_front = was_pkg::step_move(fdy, fdy_sq, fdx_sq);

   always_comb begin
      mv_x            = take_front ? mv_x_front : mv_x_cur;
      mv_y            = take_front ? mv_y_front : mv_y_cur;
      target_x_in     = target_x_ff;
      target_y_in     = target_y_ff;
      target_r_in     = target_r_ff;
      target_valid_in = target_valid_ff;
      head_in         = head_ff;
      count_in        = count_ff;
      ring_we         = 1'b0;
      ring_x_in       = in_wp_x_ff;
      ring_y_in       = in_wp_y_ff;
      ring_r_in       = in_wp_r_ff;
      rsp_x_in        = in_cur_x_ff;
      rsp_y_in        = in_cur_y_ff;
      rsp_status_in   = was_pkg::STATUS_OK;
      if (is_add) begin
         if (queue_full) begin
            rsp_status_in = was_pkg::STATUS_FULL;
         end else begin
            ring_we  = 1'b1;
            count_in = count_ff + 1'b1;
         end
      end else begin
         if (take_front) begin
            // Rotate the old destination to the back; a missing one is dropped.
            if (target_valid_ff) begin
               ring_we   = 1'b1;
               ring_x_in = target_x_ff;
               ring_y_in = target_y_ff;
               ring_r_in = target_r_ff;
            end else begin
               count_in = count_ff - 1'b1;
            end
            head_in         = head_next;
            target_x_in     = front_x;
            target_y_in     = front_y;
            target_r_in     = front_r;
            target_valid_in = 1'b1;
         end
         if (target_valid_in) begin
            rsp_x_in = was_pkg::apply_move(in_cur_x_ff, mv_x);
            rsp_y_in = was_pkg::apply_move(in_cur_y_ff, mv_y);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_func_ff  <= was_pkg::func_type'(req_func);
         in_cur_x_ff <= req_cur_x;
         in_cur_y_ff <= req_cur_y;
         in_wp_x_ff  <= req_wp_x;
         in_wp_y_ff  <= req_wp_y;
         in_wp_r_ff  <= req_wp_r;
      end
      if (advance) begin
         rsp_x_ff      <= rsp_x_in;
         rsp_y_ff      <= rsp_y_in;
         rsp_dest_ff   <= target_valid_in;
         rsp_status_ff <= rsp_status_in;
      end
      if (advance && ring_we) begin
         ring_x_ff[tail_idx] <= ring_x_in;
         ring_y_ff[tail_idx] <= ring_y_in;
         ring_r_ff[tail_idx] <= ring_r_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         head_ff         <= '0;
         count_ff        <= '0;
         target_x_ff     <= '0;
         target_y_ff     <= '0;
         target_r_ff     <= '0;
         target_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            rsp_valid_ff    <= 1'b1;
            head_ff         <= head_in;
            count_ff        <= count_in;
            target_x_ff     <= target_x_in;
            target_y_ff     <= target_y_in;
            target_r_ff     <= target_r_in;
            target_valid_ff <= target_valid_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_desired_x       = rsp_x_ff;
   assign rsp_desired_y       = rsp_y_ff;
   assign rsp_has_destination = rsp_dest_ff;
   assign rsp_status          = rsp_status_ff;

   `WAS_ASSERT(a_count_range, count_ff <= was_pkg::COUNT_W'(was_pkg::WAYPOINT_SLOTS), "waypoint count beyond slots")
   `WAS_ASSERT(a_dest_sticky, target_valid_ff |=> target_valid_ff, "destination lost")
   `WAS_ASSERT(a_add_count, advance && is_add && !queue_full |=> count_ff == $past(count_ff) + 1'b1, "add did not grow queue")
   `WAS_ASSERT_ALWAYS(a_stall_busy, req_stall |-> in_valid_ff, "stall with empty input register")

endmodule

// File: sim/tb_waypoint_agent_step.sv
module tb_waypoint_agent_step;

   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int DRAIN_CYCLES     = 10;
   localparam int RANDOM_PER_PHASE = 438;
   localparam int PHASE_IDLE  [4] = '{0, 74, 0, 28};
   localparam int PHASE_STALL [4] = '{0, 0, 74, 28};
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      was_pkg::func_type   func;
      was_pkg::coord_type  cur_x;
      was_pkg::coord_type  cur_y;
      was_pkg::coord_type  wp_x;
      was_pkg::coord_type  wp_y;
      was_pkg::radius_type wp_r;
   } agent_word_type;

   typedef struct packed {
      was_pkg::coord_type  desired_x;
      was_pkg::coord_type  desired_y;
      logic                has_dest;
      was_pkg::status_type status;
   } step_result_type;

   // known != 0: the result columns hold the answer, otherwise it is predicted
   typedef struct packed {
      int func;
      int cx;
      int cy;
      int wx;
      int wy;
      int wr;
      int known;
      int ex;
      int ey;
      int eh;
      int es;
   } directed_row_type;

   localparam directed_row_type DIRECTED_ROWS [25] = '{
      '{was_pkg::FUNC_STEP, -32768, 32767, 0, 0, 0,     1, -32768, 32767, 0, was_pkg::STATUS_OK},
      '{was_pkg::FUNC_STEP, 0, 0, 32767, -32768, 65535, 1, 0, 0, 0, was_pkg::STATUS_OK},
      '{was_pkg::FUNC_ADD, 5, -5, 32767, -32768, 65535, 1, 5, -5, 0, was_pkg::STATUS_OK},
      '{was_pkg::FUNC_STEP, -32768, 32767, 0, 0, 0,     0, 0, 0, 0, was_pkg::STATUS_OK},
      '{was_pkg::FUNC_STEP, 32767, -32768, 0, 0, 0,     1, 32767, -32768, 1, was_pkg::STATUS_OK},
      '{was_pkg::FUNC_ADD, 1, 1, 100, 100, 0,           1, 1, 1, 1, was_pkg::STATUS_OK},
      '{was_pkg::FUNC_ADD, 2, 2, -100, 50, 5,           1, 2, 2, 1, was_pkg::STATUS_OK},
      '{was_pkg::FUNC_ADD, 3, 3, 0, 0, 1,               1, 3, 3, 1, was_pkg::STATUS_OK},
      '{was_pkg::FUNC_ADD, 4, 4, 3, 4, 5,               1, 4, 4, 1, was_pkg::STATUS_OK},
      '{was_pkg::FUNC_ADD, 5, 5, -32768, 32767, 0,      1, 5, 5, 1, was_pkg::STATUS_OK},
      '{was_pkg::FUNC_ADD, 6, 6, 12, -7, 3,             1, 6, 6, 1, was_pkg::STATUS_OK},
      '{was_pkg::FUNC_ADD, 7, 7, 1000, -1000, 20,       1, 7, 7, 1, was_pkg::STATUS_OK},
      '{was_pkg::FUNC_ADD, -1, -1, -1, -1, 2,           1, -1, -1, 1, was_pkg::STATUS_OK},
      '{was_pkg::FUNC_ADD, 9, 9, 0, 32767, 65535,       1, 9, 9, 1, was_pkg::STATUS_OK},
      '{was_pkg::FUNC_ADD, 10, 10, -32768, 0, 7,        1, 10, 10, 1, was_pkg::STATUS_OK},
      '{was_pkg::FUNC_ADD, 11, 11, 200, -200, 10,       1, 11, 11, 1, was_pkg::STATUS_OK},
      '{was_pkg::FUNC_ADD, 12, 12, 7, 7, 1,             1, 12, 12, 1, was_pkg::STATUS_OK},
      '{was_pkg::FUNC_ADD, 13, 13, -50, -60, 4,         1, 13, 13, 1, was_pkg::STATUS_OK},
      '{was_pkg::FUNC_ADD, 14, 14, 32767, 32767, 9,     1, 14, 14, 1, was_pkg::STATUS_OK},
      '{was_pkg::FUNC_ADD, 15, 15, -32768, -32768, 12,  1, 15, 15, 1, was_pkg::STATUS_OK},
      '{was_pkg::FUNC_ADD, 1, 2, 42, 42, 42,            1, 1, 2, 1, was_pkg::STATUS_OK},
      '{was_pkg::FUNC_ADD, -3, 9, 1, 1, 1,              1, -3, 9, 1, was_pkg::STATUS_FULL},
      '{was_pkg::FUNC_STEP, 32767, -32768, 0, 0, 0,     0, 0, 0, 0, was_pkg::STATUS_OK},
      '{was_pkg::FUNC_STEP, 103, 104, 0, 0, 0,          0, 0, 0, 0, was_pkg::STATUS_OK},
      '{was_pkg::FUNC_STEP, 100, 100, 0, 0, 0,          1, 100, 100, 1, was_pkg::STATUS_OK}
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_func = 1'b0;
   was_pkg::coord_type  req_cur_x = '0;
   was_pkg::coord_type  req_cur_y = '0;
   was_pkg::coord_type  req_wp_x = '0;
   was_pkg::coord_type  req_wp_y = '0;
   was_pkg::radius_type req_wp_r = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   was_pkg::coord_type  rsp_desired_x;
   was_pkg::coord_type  rsp_desired_y;
   logic                rsp_has_destination;
   logic                rsp_status;

   waypoint_agent_step uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_cur_x           (req_cur_x),
      .req_cur_y           (req_cur_y),
      .req_wp_x            (req_wp_x),
      .req_wp_y            (req_wp_y),
      .req_wp_r            (req_wp_r),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_desired_x       (rsp_desired_x),
      .rsp_desired_y       (rsp_desired_y),
      .rsp_has_destination (rsp_has_destination),
      .rsp_status          (rsp_status)
   );

   always #5 clock = ~clock;

   // Agent state as the testbench sees it
   was_pkg::coord_type  queued_x [was_pkg::WAYPOINT_SLOTS];
   was_pkg::coord_type  queued_y [was_pkg::WAYPOINT_SLOTS];
   was_pkg::radius_type queued_r [was_pkg::WAYPOINT_SLOTS];
   int unsigned         queue_front = 0;
   int unsigned         queue_fill  = 0;
   was_pkg::coord_type  dest_x = '0;
   was_pkg::coord_type  dest_y = '0;
   was_pkg::radius_type dest_r = '0;
   bit                  dest_held = 1'b0;

   step_result_type predicted_steps [$];
   int unsigned     mismatch_count = 0;
   int unsigned     idle_cycles = 0;
   int unsigned     req_idle_pct = 0;
   int unsigned     rsp_stall_pct = 0;

   function automatic void add_expected(input step_result_type r);
      predicted_steps.insert(predicted_steps.size(), r);
   endfunction

   function automatic step_result_type take_expected();
      step_result_type r;
      r = predicted_steps[0];
      predicted_steps.delete(0);
      return r;
   endfunction

   function automatic int axis_step(input longint d, input longint other);
      if (3 * d * d >= other * other) begin
         if (d > 0) return 1;
         if (d < 0) return -1;
      end
      return 0;
   endfunction

   function automatic step_result_type advance_agent(input agent_word_type w);
      step_result_type     res;
      longint              dx;
      longint              dy;
      int unsigned         slot;
      bit                  arrived;
      was_pkg::coord_type  fx;
      was_pkg::coord_type  fy;
      was_pkg::radius_type fr;
      res.desired_x = w.cur_x;
      res.desired_y = w.cur_y;
      res.status    = was_pkg::STATUS_OK;
      if (w.func == was_pkg::FUNC_ADD) begin
         if (queue_fill >= was_pkg::WAYPOINT_SLOTS) begin
            res.status = was_pkg::STATUS_FULL;
         end else begin
            slot = (queue_front + queue_fill) % was_pkg::WAYPOINT_SLOTS;
            queued_x[slot] = w.wp_x;
            queued_y[slot] = w.wp_y;
            queued_r[slot] = w.wp_r;
            queue_fill++;
         end
      end else begin
         arrived = 1'b0;
         if (dest_held) begin
            dx = longint'(dest_x) - longint'(w.cur_x);
            dy = longint'(dest_y) - longint'(w.cur_y);
            arrived = (dx * dx + dy * dy) < longint'(dest_r) * longint'(dest_r);
         end
         if ((arrived || !dest_held) && queue_fill > 0) begin
            // read the front before the old destination may overwrite it
            fx = queued_x[queue_front];
            fy = queued_y[queue_front];
            fr = queued_r[queue_front];
            if (dest_held) begin
               slot = (queue_front + queue_fill) % was_pkg::WAYPOINT_SLOTS;
               queued_x[slot] = dest_x;
               queued_y[slot] = dest_y;
               queued_r[slot] = dest_r;
            end else begin
               queue_fill--;
            end
            queue_front = (queue_front + 1) % was_pkg::WAYPOINT_SLOTS;
            dest_x    = fx;
            dest_y    = fy;
            dest_r    = fr;
            dest_held = 1'b1;
         end
         if (dest_held) begin
            dx = longint'(dest_x) - longint'(w.cur_x);
            dy = longint'(dest_y) - longint'(w.cur_y);
            res.desired_x = was_pkg::coord_type'(longint'(w.cur_x) + axis_step(dx, dy));
            res.desired_y = was_pkg::coord_type'(longint'(w.cur_y) + axis_step(dy, dx));
         end
      end
      res.has_dest = dest_held;
      return res;
   endfunction

   function automatic was_pkg::coord_type near_coord(input was_pkg::coord_type c,
                                                     input int span);
      longint v;
      v = longint'(c) + longint'($urandom_range(2 * span)) - span;
      if (v < -32768 || v > 32767) return c;
      return was_pkg::coord_type'(v);
   endfunction

   // Mostly steps that land on or around the destination so that arrivals and
   // rotations happen often; the rest are full-range positions.
   function automatic agent_word_type random_word();
      agent_word_type w;
      int unsigned    roll;
      w.cur_x = was_pkg::coord_type'($urandom);
      w.cur_y = was_pkg::coord_type'($urandom);
      w.wp_x  = was_pkg::coord_type'($urandom);
      w.wp_y  = was_pkg::coord_type'($urandom);
      w.wp_r  = was_pkg::radius_type'($urandom);
      roll = $urandom_range(9);
      if ($urandom_range(99) < 20) begin
         w.func = was_pkg::FUNC_ADD;
         if (roll < 6) begin
            w.wp_r = was_pkg::radius_type'($urandom_range(12));
         end else if (roll < 8) begin
            w.wp_r = was_pkg::radius_type'($urandom_range(300));
         end
      end else begin
         w.func = was_pkg::FUNC_STEP;
         if (dest_held && roll < 5) begin
            w.cur_x = near_coord(dest_x, 15);
            w.cur_y = near_coord(dest_y, 15);
         end else if (dest_held && roll < 6) begin
            w.cur_x = dest_x;
            w.cur_y = dest_y;
         end
      end
      return w;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_word(input agent_word_type w, input bit known,
                            input step_result_type known_res);
      step_result_type res;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= w.func;
      req_cur_x <= w.cur_x;
      req_cur_y <= w.cur_y;
      req_wp_x  <= w.wp_x;
      req_wp_y  <= w.wp_y;
      req_wp_r  <= w.wp_r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      res = advance_agent(w);
      add_expected(known ? known_res : res);
      @(negedge clock);
   endtask

   task automatic report_mismatch(input bit had_want, input step_result_type want,
                                  input step_result_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         if (had_want) begin
            $display("mismatch: expected x=%0d y=%0d dest=%0b status=%0d, %s",
                     want.desired_x, want.desired_y, want.has_dest, want.status,
                     $sformatf("got x=%0d y=%0d dest=%0b status=%0d",
                               got.desired_x, got.desired_y, got.has_dest, got.status));
         end else begin
            $display("unexpected result word: x=%0d y=%0d dest=%0b status=%0d",
                     got.desired_x, got.desired_y, got.has_dest, got.status);
         end
      end
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin : check_results
      step_result_type got;
      step_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_desired_x, rsp_desired_y, rsp_has_destination,
                 was_pkg::status_type'(rsp_status)};
         if (predicted_steps.size() == 0) begin
            report_mismatch(1'b0, got, got);
         end else begin
            want = take_expected();
            if (got.desired_x !== want.desired_x || got.desired_y !== want.desired_y ||
                got.has_dest !== want.has_dest || got.status !== want.status) begin
               report_mismatch(1'b1, want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin : stimulus
      agent_word_type   w;
      step_result_type  known_res;
      directed_row_type row;
      known_res = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int phase = 0; phase < 4; phase++) begin
         req_idle_pct  = PHASE_IDLE[phase];
         rsp_stall_pct = PHASE_STALL[phase];
         if (phase == 0) begin
            foreach (DIRECTED_ROWS[i]) begin
               row = DIRECTED_ROWS[i];
               w.func    = was_pkg::func_type'(row.func);
               w.cur_x   = was_pkg::coord_type'(row.cx);
               w.cur_y   = was_pkg::coord_type'(row.cy);
               w.wp_x    = was_pkg::coord_type'(row.wx);
               w.wp_y    = was_pkg::coord_type'(row.wy);
               w.wp_r    = was_pkg::radius_type'(row.wr);
               known_res = '{was_pkg::coord_type'(row.ex), was_pkg::coord_type'(row.ey),
                             row.eh[0], was_pkg::status_type'(row.es)};
               send_word(w, row.known != 0, known_res);
            end
         end
         repeat (RANDOM_PER_PHASE) send_word(random_word(), 1'b0, known_res);
         // hold off until every result of this phase is back
         req_valid <= 1'b0;
         while (predicted_steps.size() != 0) @(negedge clock);
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && predicted_steps.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
